// ===== design/flbt_pkg.sv =====
// Shared types, constants and field layouts for the failed-login ban table.
package flbt_pkg;

  // Table size default and field widths.
  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned ADDR_W          = 64;
  localparam int unsigned ATT_W           = 8;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned FCNT_W          = 16;
  localparam int unsigned ACT_W           = 2;
  localparam int unsigned STAT_W          = 2;
  localparam int unsigned ENTRY_CNT_W     = 7;
  localparam logic [FCNT_W-1:0] FCNT_MAX  = '1;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 200;
  localparam int unsigned S_TUSER_W = 8;
  localparam int unsigned OUT_USED_W = 1 + STAT_W + 2 * ENTRY_CNT_W;
  localparam int unsigned M_TDATA_W = 24;

  // Bit positions of the result fields in the output tdata.
  localparam int unsigned OUT_BANNED_BIT = 0;
  localparam int unsigned OUT_STAT_LSB   = 1;
  localparam int unsigned OUT_STAT_MSB   = OUT_STAT_LSB + STAT_W - 1;
  localparam int unsigned OUT_ECNT_LSB   = OUT_STAT_MSB + 1;
  localparam int unsigned OUT_RCNT_LSB   = OUT_ECNT_LSB + ENTRY_CNT_W;
  localparam int unsigned OUT_RCNT_MSB   = OUT_RCNT_LSB + ENTRY_CNT_W - 1;

  // Action codes carried in tuser.
  typedef enum logic [ACT_W-1:0] {
    ACT_RECORD = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_CHECK  = 2'd2,
    ACT_SWEEP  = 2'd3
  } action_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_e;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic [FCNT_W-1:0] cnt;
    logic [TIME_W-1:0] exp;
  } entry_t;

  // Flags from the entry compare unit.
  typedef struct packed {
    logic addr_eq;
    logic now_gt_exp;
    logic now_ge_exp;
  } cmp_t;

endpackage

// ===== design/flbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module flbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/flbt_cmp.sv =====
// Entry compare unit: address match and expiry tests for one table entry.
module flbt_cmp
  import flbt_pkg::*;
(
  input  entry_t            entry_i,
  input  logic [ADDR_W-1:0] key_hi_i,
  input  logic [ADDR_W-1:0] key_lo_i,
  input  logic [TIME_W-1:0] now_i,
  output cmp_t              cmp_o
);

  // A 128-bit equality and two unsigned time compares (greater-than and greater-or-equal), shared by every action.
  always_comb begin
    cmp_o.addr_eq    = (entry_i.hi == key_hi_i) && (entry_i.lo == key_lo_i);
    cmp_o.now_gt_exp = now_i > entry_i.exp;
    cmp_o.now_ge_exp = (now_i > entry_i.exp) || (now_i == entry_i.exp);
  end

endmodule

// ===== design/failed_login_ban_table_core.sv =====
// Top level of the failed-login ban table: scan sequencer, valid bits and result register.
//
//  Channel   Direction  Handshake                    Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  action, address, attempts, times
//  m_axis    out        m_axis_tvalid/m_axis_tready  banned, status, entry and removed counts
//  cfg       in         cfg_valid_i/cfg_ready_o      max_tries
//
// Each item is handled in turn: the entry RAM's single read port walks every slot once,
// a finish state completes the update, and the sequencer returns to idle, where the next
// transfer is accepted; no new item is taken while one is still being scanned or finished.
// Reset clears every valid bit, the occupancy and max_tries (to 3) at once; no clearing
// pass is needed. A stalled result sits in the output register while the next item
// is accepted and scanned; that item then waits in its finish cycle for the register.
module failed_login_ban_table_core
  import flbt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // From bit 0: addr_high[63:0], addr_low[127:64], attempts[135:128],
  // expiry_time[167:136], now_time[199:168].
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // From bit 0: action[1:0], zero fill above.
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  // Result items.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // From bit 0: banned[0], status[2:1], entry_count[9:3], removed_count[16:10],
  // zero fill above.
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // Configuration write.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [FCNT_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Latched item.
  action_e           act_q;
  logic [ADDR_W-1:0] hi_q, lo_q;
  logic [ATT_W-1:0]  att_q;
  logic [TIME_W-1:0] exp_q, now_q;

  // Configuration and table state.
  logic [FCNT_W-1:0] max_tries_q;
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CNT_W-1:0]  occ_q;

  // Scan bookkeeping.
  logic [CNT_W-1:0]  scan_q;
  logic              rsp_vld_q;
  logic [AW-1:0]     rsp_idx_q;
  logic              rsp_vbit_q;
  logic              hit_q;
  logic [AW-1:0]     hit_idx_q;
  logic [FCNT_W-1:0] hit_cnt_q;
  logic              hit_gt_q;
  logic              free_vld_q;
  logic [AW-1:0]     free_idx_q;
  logic [CNT_W-1:0]  removed_q;

  // Result register.
  logic                   out_vld_q;
  logic                   out_banned_q;
  status_e                out_stat_q;
  logic [ENTRY_CNT_W-1:0] out_ecnt_q, out_rcnt_q;

  // RAM and compare unit.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata, ram_rdata;
  cmp_t          cmp;

  // Finish-cycle results.
  logic             fin_go;
  logic             set_valid;
  logic             res_banned;
  status_e          res_stat;
  logic [CNT_W-1:0] occ_next;
  logic [FCNT_W:0]  sum;
  logic [FCNT_W-1:0] cnt_base, cnt_new;
  logic [CNT_W+ENTRY_CNT_W-1:0] occ_ext, rem_ext;

  logic s_xfer, scan_end;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign scan_end      = (scan_q == CNT_W'(TABLE_DEPTH));
  assign fin_go        = (state_q == ST_FINISH) && (!out_vld_q || m_axis_tready);

  flbt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  flbt_cmp u_cmp (
    .entry_i  (ram_rdata),
    .key_hi_i (hi_q),
    .key_lo_i (lo_q),
    .now_i    (now_q),
    .cmp_o    (cmp)
  );

  assign ram_re = (state_q == ST_SCAN) && !scan_end;

  // State sequencing.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_xfer) state_d = ST_SCAN;
      ST_SCAN:   if (scan_end) state_d = ST_FINISH;
      ST_FINISH: if (fin_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Finish-cycle update: entry write, valid set, occupancy, status and ban decision.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = hit_idx_q;
    set_valid  = 1'b0;
    res_banned = 1'b0;
    res_stat   = STAT_DONE;
    occ_next   = occ_q;
    cnt_base   = hit_gt_q ? '0 : hit_cnt_q;
    if (!hit_q) begin
      cnt_base = '0;
    end
    sum        = {1'b0, cnt_base} + {{(FCNT_W + 1 - ATT_W){1'b0}}, att_q};
    cnt_new    = sum[FCNT_W] ? FCNT_MAX : sum[FCNT_W-1:0];
    ram_wdata.hi  = hi_q;
    ram_wdata.lo  = lo_q;
    ram_wdata.cnt = cnt_new;
    ram_wdata.exp = exp_q;
    case (act_q)
      ACT_RECORD: begin
        if (hit_q) begin
          ram_we = fin_go;
        end else if (free_vld_q) begin
          ram_we    = fin_go;
          ram_waddr = free_idx_q;
          set_valid = fin_go;
          occ_next  = occ_q + CNT_W'(1);
        end else begin
          res_stat = STAT_FULL;
        end
      end
      ACT_CLEAR: begin
        ram_wdata.cnt = '0;
        ram_wdata.exp = '0;
        if (hit_q) begin
          ram_we = fin_go;
        end else begin
          res_stat = STAT_ABSENT;
        end
      end
      ACT_CHECK: begin
        if (hit_q) begin
          res_banned = !hit_gt_q && (hit_cnt_q >= max_tries_q);
        end else begin
          res_stat = STAT_ABSENT;
        end
      end
      ACT_SWEEP: begin
        occ_next = occ_q - removed_q;
      end
      default: begin
        res_stat = STAT_DONE;
      end
    endcase
  end

  // Count fields carry the low bits of the true counts.
  assign occ_ext = {{ENTRY_CNT_W{1'b0}}, occ_next};
  assign rem_ext = {{ENTRY_CNT_W{1'b0}}, (act_q == ACT_SWEEP) ? removed_q : CNT_W'(0)};

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_tries_q <= FCNT_W'(3);
      valid_q     <= '0;
      occ_q       <= '0;
      scan_q      <= '0;
      rsp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_vld_q  <= 1'b0;
      removed_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        max_tries_q <= cfg_wdata_i;
      end
      // Start of a scan.
      if (s_xfer) begin
        scan_q     <= '0;
        hit_q      <= 1'b0;
        free_vld_q <= 1'b0;
        removed_q  <= '0;
      end
      // Read issue; the response lands in the following cycle.
      rsp_vld_q <= ram_re;
      if (ram_re) begin
        scan_q <= scan_q + CNT_W'(1);
      end
      // Evaluate the returned entry.
      if (rsp_vld_q) begin
        if (rsp_vbit_q && cmp.addr_eq && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!rsp_vbit_q && !free_vld_q) begin
          free_vld_q <= 1'b1;
        end
        if (act_q == ACT_SWEEP && rsp_vbit_q && cmp.now_ge_exp) begin
          valid_q[rsp_idx_q] <= 1'b0;
          removed_q          <= removed_q + CNT_W'(1);
        end
      end
      if (set_valid) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      if (fin_go) begin
        occ_q <= occ_next;
      end
      // Result register.
      if (fin_go) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      act_q <= action_e'(s_axis_tuser[ACT_W-1:0]);
      hi_q  <= s_axis_tdata[ADDR_W-1:0];
      lo_q  <= s_axis_tdata[2*ADDR_W-1:ADDR_W];
      att_q <= s_axis_tdata[2*ADDR_W+ATT_W-1:2*ADDR_W];
      exp_q <= s_axis_tdata[2*ADDR_W+ATT_W+TIME_W-1:2*ADDR_W+ATT_W];
      now_q <= s_axis_tdata[2*ADDR_W+ATT_W+2*TIME_W-1:2*ADDR_W+ATT_W+TIME_W];
    end
    rsp_idx_q <= scan_q[AW-1:0];
    // The valid bit of the slot being read is registered alongside the RAM data.
    if (ram_re) begin
      rsp_vbit_q <= valid_q[scan_q[AW-1:0]];
    end
    if (rsp_vld_q && rsp_vbit_q && cmp.addr_eq && !hit_q) begin
      hit_idx_q <= rsp_idx_q;
      hit_cnt_q <= ram_rdata.cnt;
      hit_gt_q  <= cmp.now_gt_exp;
    end
    if (rsp_vld_q && !rsp_vbit_q && !free_vld_q) begin
      free_idx_q <= rsp_idx_q;
    end
    if (fin_go) begin
      out_banned_q <= res_banned;
      out_stat_q   <= res_stat;
      out_ecnt_q   <= occ_ext[ENTRY_CNT_W-1:0];
      out_rcnt_q   <= rem_ext[ENTRY_CNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(M_TDATA_W - OUT_USED_W){1'b0}},
                          out_rcnt_q, out_ecnt_q, out_stat_q, out_banned_q};

endmodule

// ===== design/flbt_checker.sv =====
// Port-level assertions for the ban table core, with the bind that attaches them.
module flbt_checker
  import flbt_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Once an item is taken the scan keeps the input side closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted during a scan");

  // Status is always one of the defined codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_STAT_MSB:OUT_STAT_LSB] == STAT_DONE ||
                       m_axis_tdata[OUT_STAT_MSB:OUT_STAT_LSB] == STAT_FULL ||
                       m_axis_tdata[OUT_STAT_MSB:OUT_STAT_LSB] == STAT_ABSENT))
    else $error("undefined status code");

  // A ban or a removal only comes with a successful status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[OUT_BANNED_BIT] ||
                      m_axis_tdata[OUT_RCNT_MSB:OUT_RCNT_LSB] != '0)
    |-> m_axis_tdata[OUT_STAT_MSB:OUT_STAT_LSB] == STAT_DONE)
    else $error("ban or removal reported with failing status");

endmodule

bind failed_login_ban_table_core flbt_checker u_flbt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
